// ----- design/mvs_pkg.sv -----
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared types, codes and the marker decoder of the MessagePack value skipper.
// ----------------------------------------------------------------------------
package mvs_pkg;

  localparam int MAX_DEPTH_DEF = 128;
  localparam logic [23:0] ITEM_LIMIT_RST = 24'd8388608;
  localparam logic [7:0] MARK_RESERVED = 8'hC1;

  localparam logic [1:0] ROLE_MARKER  = 2'd0;
  localparam logic [1:0] ROLE_LENGTH  = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RESERVED = 3'd1;
  localparam logic [2:0] ERR_ITEMS    = 3'd2;
  localparam logic [2:0] ERR_DEEP     = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FIN, S_LOAD, S_OUT} state_t;
  typedef enum logic [1:0] {PH_MARKER, PH_LENGTH, PH_PAYLOAD} phase_t;
  typedef enum logic [1:0] {KIND_BYTES, KIND_EXT, KIND_ARRAY, KIND_MAP} kind_t;
  typedef enum logic [1:0] {ACT_SCALAR, ACT_PAYLOAD, ACT_OPEN, ACT_LENGTH} act_t;

  typedef struct packed {
    act_t       act;
    logic [4:0] num;
    logic [2:0] lbytes;
    kind_t      kind;
  } mark_dec_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic fin;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic exec_fin;
    logic fin_cont;
    logic out_free;
  } sts_t;

  function automatic mark_dec_t decode_marker(input logic [7:0] m);
    mark_dec_t d;
    d.act    = ACT_SCALAR;
    d.num    = 5'd0;
    d.lbytes = 3'd0;
    d.kind   = KIND_BYTES;
    if (m <= 8'h7F || m >= 8'hE0 || m == 8'hC0 || m == 8'hC2 || m == 8'hC3) begin
      d.act = ACT_SCALAR;
    end else if (m[7:5] == 3'b101) begin
      d.act = ACT_PAYLOAD;
      d.num = m[4:0];
    end else if (m[7:4] == 4'h9) begin
      d.act = ACT_OPEN;
      d.num = {1'b0, m[3:0]};
    end else if (m[7:4] == 4'h8) begin
      d.act = ACT_OPEN;
      d.num = {m[3:0], 1'b0};
    end else begin
      case (m)
        8'hC4, 8'hD9: begin d.act = ACT_LENGTH; d.lbytes = 3'd1; end
        8'hC5, 8'hDA: begin d.act = ACT_LENGTH; d.lbytes = 3'd2; end
        8'hC6, 8'hDB: begin d.act = ACT_LENGTH; d.lbytes = 3'd4; end
        8'hC7: begin d.act = ACT_LENGTH; d.lbytes = 3'd1; d.kind = KIND_EXT; end
        8'hC8: begin d.act = ACT_LENGTH; d.lbytes = 3'd2; d.kind = KIND_EXT; end
        8'hC9: begin d.act = ACT_LENGTH; d.lbytes = 3'd4; d.kind = KIND_EXT; end
        8'hDC: begin d.act = ACT_LENGTH; d.lbytes = 3'd2; d.kind = KIND_ARRAY; end
        8'hDD: begin d.act = ACT_LENGTH; d.lbytes = 3'd4; d.kind = KIND_ARRAY; end
        8'hDE: begin d.act = ACT_LENGTH; d.lbytes = 3'd2; d.kind = KIND_MAP; end
        8'hDF: begin d.act = ACT_LENGTH; d.lbytes = 3'd4; d.kind = KIND_MAP; end
        8'hCC, 8'hD0: begin d.act = ACT_PAYLOAD; d.num = 5'd1; end
        8'hCD, 8'hD1, 8'hD4: begin d.act = ACT_PAYLOAD; d.num = 5'd2; end
        8'hD5: begin d.act = ACT_PAYLOAD; d.num = 5'd3; end
        8'hCA, 8'hCE, 8'hD2: begin d.act = ACT_PAYLOAD; d.num = 5'd4; end
        8'hD6: begin d.act = ACT_PAYLOAD; d.num = 5'd5; end
        8'hCB, 8'hCF, 8'hD3: begin d.act = ACT_PAYLOAD; d.num = 5'd8; end
        8'hD7: begin d.act = ACT_PAYLOAD; d.num = 5'd9; end
        8'hD8: begin d.act = ACT_PAYLOAD; d.num = 5'd17; end
        default: d.act = ACT_SCALAR;
      endcase
    end
    return d;
  endfunction

endpackage

// ----- design/mvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mvs_ctrl
// Sequencer: accept a word, execute it, walk container closes, emit result.
// ----------------------------------------------------------------------------
module mvs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mvs_pkg::sts_t sts,
  output mvs_pkg::cmd_t cmd
);

  mvs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      mvs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = mvs_pkg::S_EXEC;
        end
      end
      mvs_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.exec_fin ? mvs_pkg::S_FIN : mvs_pkg::S_OUT;
      end
      mvs_pkg::S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sts.fin_cont ? mvs_pkg::S_LOAD : mvs_pkg::S_OUT;
      end
      mvs_pkg::S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = mvs_pkg::S_FIN;
      end
      mvs_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mvs_pkg::S_IDLE;
        end
      end
      default: state_nxt = mvs_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- design/mvs_dp.sv -----
// ----------------------------------------------------------------------------
// mvs_dp
// Datapath: parse registers, child count stack, item limit and result register.
// ----------------------------------------------------------------------------
module mvs_dp #(
  parameter int MAX_DEPTH = mvs_pkg::MAX_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mvs_pkg::cmd_t cmd,
  output mvs_pkg::sts_t sts,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          cfg_valid,
  input  logic [23:0]   cfg_item_limit,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_byte_role,
  output logic [7:0]    out_nesting_depth,
  output logic [7:0]    out_levels_closed,
  output logic          out_value_done,
  output logic [2:0]    out_error_code
);

  localparam int LVW = $clog2(MAX_DEPTH + 2);
  localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [LVW-1:0] LVL_MAX = LVW'(MAX_DEPTH);

  logic [24:0] stack_mem [MAX_DEPTH];
  logic [24:0] rdata_r;

  logic [23:0]     limit_r;
  logic [7:0]      byte_r;
  logic            last_r;
  logic [LVW-1:0]  level_r, level_nxt;
  mvs_pkg::phase_t phase_r, phase_nxt;
  mvs_pkg::kind_t  kind_r, kind_nxt;
  logic [2:0]      lb_r, lb_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [32:0]     pay_r, pay_nxt;
  logic [24:0]     top_r, top_nxt;
  logic [2:0]      err_r, err_nxt;
  logic [2:0]      cur_err_r, cur_err_nxt;
  logic [1:0]      role_r, role_nxt;
  logic [7:0]      depth_r, depth_nxt;
  logic [LVW-1:0]  closed_r, closed_nxt;
  logic            done_r, done_nxt;
  logic            out_valid_r;
  logic [1:0]      o_role_r;
  logic [7:0]      o_depth_r, o_closed_r;
  logic            o_done_r;
  logic [2:0]      o_err_r;

  logic              push, pop_rd;
  logic              pay_go, open_go, fin_go;
  logic [32:0]       pay_n;
  logic [24:0]       open_n;
  logic [2:0]        final_err;
  mvs_pkg::mark_dec_t dec;

  always_comb begin
    level_nxt   = level_r;
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    lb_nxt      = lb_r;
    acc_nxt     = acc_r;
    pay_nxt     = pay_r;
    top_nxt     = top_r;
    err_nxt     = err_r;
    cur_err_nxt = cur_err_r;
    role_nxt    = role_r;
    depth_nxt   = depth_r;
    closed_nxt  = closed_r;
    done_nxt    = done_r;
    push        = 1'b0;
    pop_rd      = 1'b0;
    pay_go      = 1'b0;
    open_go     = 1'b0;
    fin_go      = 1'b0;
    pay_n       = '0;
    open_n      = '0;
    sts         = '0;
    dec         = mvs_pkg::decode_marker(byte_r);
    final_err   = cur_err_r;
    if (cur_err_r == mvs_pkg::ERR_NONE && last_r
        && (level_r != '0 || phase_r != mvs_pkg::PH_MARKER)) begin
      final_err = mvs_pkg::ERR_TRUNC;
    end
    sts.out_free = !out_valid_r || out_ready;

    if (cmd.exec) begin
      closed_nxt  = '0;
      done_nxt    = 1'b0;
      if (err_r != mvs_pkg::ERR_NONE) begin
        cur_err_nxt = err_r;
        role_nxt    = mvs_pkg::ROLE_MARKER;
        depth_nxt   = 8'd0;
      end else begin
        cur_err_nxt = mvs_pkg::ERR_NONE;
        depth_nxt   = 8'(level_r);
        case (phase_r)
          mvs_pkg::PH_LENGTH: begin
            role_nxt = mvs_pkg::ROLE_LENGTH;
            acc_nxt  = {acc_r[23:0], byte_r};
            lb_nxt   = lb_r - 3'd1;
            if (lb_r == 3'd1) begin
              case (kind_r)
                mvs_pkg::KIND_BYTES: begin
                  pay_go = 1'b1;
                  pay_n  = {1'b0, acc_nxt};
                end
                mvs_pkg::KIND_EXT: begin
                  pay_go = 1'b1;
                  pay_n  = {1'b0, acc_nxt} + 33'd1;
                end
                default: begin
                  phase_nxt = mvs_pkg::PH_MARKER;
                  if (acc_nxt > {8'd0, limit_r}) begin
                    cur_err_nxt = mvs_pkg::ERR_ITEMS;
                  end else begin
                    open_go = 1'b1;
                    open_n  = (kind_r == mvs_pkg::KIND_MAP) ? {acc_nxt[23:0], 1'b0}
                                                            : {1'b0, acc_nxt[23:0]};
                  end
                end
              endcase
            end
          end
          mvs_pkg::PH_PAYLOAD: begin
            role_nxt = mvs_pkg::ROLE_PAYLOAD;
            pay_nxt  = pay_r - 33'd1;
            if (pay_r == 33'd1) begin
              phase_nxt = mvs_pkg::PH_MARKER;
              fin_go    = 1'b1;
            end
          end
          default: begin
            role_nxt  = mvs_pkg::ROLE_MARKER;
            phase_nxt = mvs_pkg::PH_MARKER;
            if (level_r > LVL_MAX) begin
              cur_err_nxt = mvs_pkg::ERR_DEEP;
            end else if (byte_r == mvs_pkg::MARK_RESERVED) begin
              cur_err_nxt = mvs_pkg::ERR_RESERVED;
            end else begin
              case (dec.act)
                mvs_pkg::ACT_PAYLOAD: begin
                  pay_go = 1'b1;
                  pay_n  = 33'(dec.num);
                end
                mvs_pkg::ACT_OPEN: begin
                  open_go = 1'b1;
                  open_n  = 25'(dec.num);
                end
                mvs_pkg::ACT_LENGTH: begin
                  lb_nxt    = dec.lbytes;
                  acc_nxt   = '0;
                  kind_nxt  = dec.kind;
                  phase_nxt = mvs_pkg::PH_LENGTH;
                end
                default: fin_go = 1'b1;
              endcase
            end
          end
        endcase
        if (pay_go) begin
          if (pay_n == '0) begin
            phase_nxt = mvs_pkg::PH_MARKER;
            fin_go    = 1'b1;
          end else begin
            pay_nxt   = pay_n;
            phase_nxt = mvs_pkg::PH_PAYLOAD;
          end
        end
        if (open_go) begin
          if (open_n == '0) begin
            fin_go = 1'b1;
          end else if (level_r <= LVL_MAX) begin
            push      = 1'b1;
            top_nxt   = open_n;
            level_nxt = level_r + LVW'(1);
          end
        end
        sts.exec_fin = fin_go;
      end
    end

    if (cmd.fin) begin
      if (level_r == '0) begin
        done_nxt = 1'b1;
      end else if (top_r != 25'd1) begin
        top_nxt = top_r - 25'd1;
      end else begin
        level_nxt  = level_r - LVW'(1);
        closed_nxt = closed_r + LVW'(1);
        if (level_r == LVW'(1)) begin
          done_nxt = 1'b1;
        end else begin
          pop_rd       = 1'b1;
          sts.fin_cont = 1'b1;
        end
      end
    end

    if (cmd.load) begin
      top_nxt = rdata_r;
    end

    if (cmd.emit) begin
      err_nxt = final_err;
    end
  end

  always_ff @(posedge clk) begin
    if (push && level_r != '0) begin
      stack_mem[AW'(level_r - LVW'(1))] <= top_r;
    end
    if (pop_rd) begin
      rdata_r <= stack_mem[AW'(level_r - LVW'(2))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= mvs_pkg::ITEM_LIMIT_RST;
      level_r     <= '0;
      phase_r     <= mvs_pkg::PH_MARKER;
      kind_r      <= mvs_pkg::KIND_BYTES;
      lb_r        <= '0;
      acc_r       <= '0;
      pay_r       <= '0;
      top_r       <= '0;
      err_r       <= mvs_pkg::ERR_NONE;
      cur_err_r   <= mvs_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_item_limit;
      end
      level_r   <= level_nxt;
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      lb_r      <= lb_nxt;
      acc_r     <= acc_nxt;
      pay_r     <= pay_nxt;
      top_r     <= top_nxt;
      err_r     <= err_nxt;
      cur_err_r <= cur_err_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    role_r   <= role_nxt;
    depth_r  <= depth_nxt;
    closed_r <= closed_nxt;
    done_r   <= done_nxt;
    if (cmd.emit) begin
      o_role_r   <= role_r;
      o_depth_r  <= depth_r;
      o_closed_r <= 8'(closed_r);
      o_done_r   <= done_r;
      o_err_r    <= final_err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_role     = o_role_r;
  assign out_nesting_depth = o_depth_r;
  assign out_levels_closed = o_closed_r;
  assign out_value_done    = o_done_r;
  assign out_error_code    = o_err_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_MAX + LVW'(1))
    else $error("stack level beyond limit");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != mvs_pkg::ERR_NONE |=> err_r == $past(err_r))
    else $error("sticky error changed");

  a_pay_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mvs_pkg::PH_PAYLOAD |-> pay_r != '0)
    else $error("payload phase with no bytes left");

  a_frozen_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && err_r != mvs_pkg::ERR_NONE |-> role_r == mvs_pkg::ROLE_MARKER && !done_r)
    else $error("word after error not blanked");

endmodule

// ----- design/msgpack_value_skipper_core.sv -----
// ----------------------------------------------------------------------------
// msgpack_value_skipper_core
// MessagePack structure walker: one result word per stream byte.
// ----------------------------------------------------------------------------
// Each byte passes through accept, execute and emit; a byte that completes a
// value also passes through a close step, plus a load and another close step
// for every container it closes that leaves another container open, since each
// such pop reads the next child count from the stack memory before it can be
// decremented. The result register lets the next byte enter while the previous
// result waits. Configuration writes are taken every cycle.
module msgpack_value_skipper_core #(
  parameter int MAX_DEPTH = mvs_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_byte_role,
  output logic [7:0]  out_nesting_depth,
  output logic [7:0]  out_levels_closed,
  output logic        out_value_done,
  output logic [2:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_item_limit
);

  mvs_pkg::cmd_t cmd;
  mvs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mvs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvs_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .cfg_valid         (cfg_valid),
    .cfg_item_limit    (cfg_item_limit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_role     (out_byte_role),
    .out_nesting_depth (out_nesting_depth),
    .out_levels_closed (out_levels_closed),
    .out_value_done    (out_value_done),
    .out_error_code    (out_error_code)
  );

endmodule

// ----- tb/mvs_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mvs_checker
// Watches the byte, result and limit channels of the value skipper, tracks the
// stream structure per accepted byte and compares every result word in order.
// ----------------------------------------------------------------------------
module mvs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_byte_role,
  input  logic [7:0]  out_nesting_depth,
  input  logic [7:0]  out_levels_closed,
  input  logic        out_value_done,
  input  logic [2:0]  out_error_code,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [23:0] cfg_item_limit,
  output int          pending,
  output int          fails
);

  localparam int MAXD = mvs_pkg::MAX_DEPTH_DEF;

  typedef struct packed {
    logic [1:0] role;
    logic [7:0] depth;
    logic [7:0] closed;
    logic       done;
    logic [2:0] err;
  } walk_word_t;

  walk_word_t      walk_q[$];
  logic [24:0]     kids[0:MAXD];
  int unsigned     lvl;
  mvs_pkg::phase_t ph;
  mvs_pkg::kind_t  knd;
  int unsigned     len_left;
  logic [31:0]     len_acc;
  logic [32:0]     pay_left;
  logic [2:0]      sticky;
  logic [23:0]     limit;

  task automatic close_value(inout int unsigned ncl, inout logic fin);
    bit go;
    go = 1;
    while (go) begin
      if (lvl == 0) begin
        fin = 1'b1;
        go = 0;
      end else if (lvl - 1 > MAXD) begin
        go = 0;
      end else begin
        kids[lvl-1] = kids[lvl-1] - 25'd1;
        if (kids[lvl-1] != 0) go = 0;
        else begin
          lvl--;
          ncl++;
        end
      end
    end
  endtask

  task automatic open_level(input logic [31:0] cnt, inout int unsigned ncl, inout logic fin);
    if (cnt == 0) close_value(ncl, fin);
    else if (lvl <= MAXD) begin
      kids[lvl] = cnt[24:0];
      lvl++;
    end
  endtask

  task automatic begin_payload(input logic [32:0] n, inout int unsigned ncl, inout logic fin);
    if (n == 0) begin
      ph = mvs_pkg::PH_MARKER;
      close_value(ncl, fin);
    end else begin
      pay_left = n;
      ph = mvs_pkg::PH_PAYLOAD;
    end
  endtask

  task automatic begin_length(input int unsigned nb, input mvs_pkg::kind_t k);
    len_left = nb;
    len_acc = '0;
    knd = k;
    ph = mvs_pkg::PH_LENGTH;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic lst, output walk_word_t w);
    int unsigned ncl;
    logic fin;
    logic [2:0] err;
    ncl = 0;
    fin = 0;
    err = mvs_pkg::ERR_NONE;
    w = '0;
    if (sticky != mvs_pkg::ERR_NONE) begin
      w.err = sticky;
      return;
    end
    w.depth = lvl[7:0];
    if (ph == mvs_pkg::PH_LENGTH) begin
      w.role = mvs_pkg::ROLE_LENGTH;
      len_acc = {len_acc[23:0], b};
      if (len_left > 0) len_left--;
      if (len_left == 0) begin
        if (knd == mvs_pkg::KIND_BYTES) begin_payload({1'b0, len_acc}, ncl, fin);
        else if (knd == mvs_pkg::KIND_EXT) begin_payload({1'b0, len_acc} + 33'd1, ncl, fin);
        else begin
          ph = mvs_pkg::PH_MARKER;
          if (len_acc > {8'd0, limit}) err = mvs_pkg::ERR_ITEMS;
          else if (knd == mvs_pkg::KIND_MAP) open_level(len_acc << 1, ncl, fin);
          else open_level(len_acc, ncl, fin);
        end
      end
    end else if (ph == mvs_pkg::PH_PAYLOAD) begin
      w.role = mvs_pkg::ROLE_PAYLOAD;
      if (pay_left > 0) pay_left--;
      if (pay_left == 0) begin
        ph = mvs_pkg::PH_MARKER;
        close_value(ncl, fin);
      end
    end else begin
      w.role = mvs_pkg::ROLE_MARKER;
      ph = mvs_pkg::PH_MARKER;
      if (lvl > MAXD) err = mvs_pkg::ERR_DEEP;
      else if (b == mvs_pkg::MARK_RESERVED) err = mvs_pkg::ERR_RESERVED;
      else if (b <= 8'h7F || b >= 8'hE0 || b == 8'hC0 || b == 8'hC2 || b == 8'hC3)
        close_value(ncl, fin);
      else if (b[7:5] == 3'b101) begin_payload({28'd0, b[4:0]}, ncl, fin);
      else if (b[7:4] == 4'h9) open_level({28'd0, b[3:0]}, ncl, fin);
      else if (b[7:4] == 4'h8) open_level({27'd0, b[3:0], 1'b0}, ncl, fin);
      else begin
        case (b)
          8'hC4, 8'hD9: begin_length(1, mvs_pkg::KIND_BYTES);
          8'hC5, 8'hDA: begin_length(2, mvs_pkg::KIND_BYTES);
          8'hC6, 8'hDB: begin_length(4, mvs_pkg::KIND_BYTES);
          8'hC7: begin_length(1, mvs_pkg::KIND_EXT);
          8'hC8: begin_length(2, mvs_pkg::KIND_EXT);
          8'hC9: begin_length(4, mvs_pkg::KIND_EXT);
          8'hDC: begin_length(2, mvs_pkg::KIND_ARRAY);
          8'hDD: begin_length(4, mvs_pkg::KIND_ARRAY);
          8'hDE: begin_length(2, mvs_pkg::KIND_MAP);
          8'hDF: begin_length(4, mvs_pkg::KIND_MAP);
          8'hCC, 8'hD0: begin_payload(33'd1, ncl, fin);
          8'hCD, 8'hD1, 8'hD4: begin_payload(33'd2, ncl, fin);
          8'hD5: begin_payload(33'd3, ncl, fin);
          8'hCA, 8'hCE, 8'hD2: begin_payload(33'd4, ncl, fin);
          8'hD6: begin_payload(33'd5, ncl, fin);
          8'hCB, 8'hCF, 8'hD3: begin_payload(33'd8, ncl, fin);
          8'hD7: begin_payload(33'd9, ncl, fin);
          8'hD8: begin_payload(33'd17, ncl, fin);
          default: close_value(ncl, fin);
        endcase
      end
    end
    if (err == mvs_pkg::ERR_NONE && lst && (lvl != 0 || ph != mvs_pkg::PH_MARKER))
      err = mvs_pkg::ERR_TRUNC;
    if (err != mvs_pkg::ERR_NONE) sticky = err;
    w.closed = ncl[7:0];
    w.done = fin;
    w.err = err;
  endtask

  always @(posedge clk) begin
    walk_word_t w;
    walk_word_t got;
    if (!rst_n) begin
      walk_q.delete();
      lvl = 0;
      ph = mvs_pkg::PH_MARKER;
      knd = mvs_pkg::KIND_BYTES;
      len_left = 0;
      len_acc = '0;
      pay_left = '0;
      sticky = mvs_pkg::ERR_NONE;
      limit = mvs_pkg::ITEM_LIMIT_RST;
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) limit = cfg_item_limit;
      if (in_valid && in_ready) begin
        walk_byte(in_byte, in_last, w);
        walk_q.insert(walk_q.size(), w);
      end
      if (out_valid && out_ready) begin
        got = '{out_byte_role, out_nesting_depth, out_levels_closed, out_value_done,
                out_error_code};
        if (walk_q.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          w = walk_q.pop_front();
          if (got.role !== w.role) begin
            $error("byte_role expected %0d got %0d", w.role, got.role);
            fails++;
          end
          if (got.depth !== w.depth) begin
            $error("nesting_depth expected %0d got %0d", w.depth, got.depth);
            fails++;
          end
          if (got.closed !== w.closed) begin
            $error("levels_closed expected %0d got %0d", w.closed, got.closed);
            fails++;
          end
          if (got.done !== w.done) begin
            $error("value_done expected %0d got %0d", w.done, got.done);
            fails++;
          end
          if (got.err !== w.err) begin
            $error("error_code expected %0d got %0d", w.err, got.err);
            fails++;
          end
        end
      end
    end
    pending = walk_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Feeds the value skipper well-formed MessagePack streams with random content
// under several item limits, ends on one error case, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_byte_role;
  logic [7:0]  out_nesting_depth;
  logic [7:0]  out_levels_closed;
  logic        out_value_done;
  logic [2:0]  out_error_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_item_limit;
  int          pending;
  int          fails;

  logic [8:0]  strm_q[$];
  logic [23:0] cur_limit;
  int          burst_left;

  msgpack_value_skipper_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte_role(out_byte_role), .out_nesting_depth(out_nesting_depth),
    .out_levels_closed(out_levels_closed), .out_value_done(out_value_done),
    .out_error_code(out_error_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_item_limit(cfg_item_limit)
  );

  mvs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte_role(out_byte_role), .out_nesting_depth(out_nesting_depth),
    .out_levels_closed(out_levels_closed), .out_value_done(out_value_done),
    .out_error_code(out_error_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_item_limit(cfg_item_limit),
    .pending(pending), .fails(fails)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic put(input logic [7:0] b);
    strm_q.insert(strm_q.size(), {1'b0, b});
  endtask

  task automatic put_be(input logic [31:0] v, input int nb);
    for (int i = nb - 1; i >= 0; i--) put(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
  endtask

  task automatic gen_value(input int d);
    int sel;
    int n;
    int nb;
    logic [7:0] m;
    sel = $urandom_range(0, 11);
    if (d >= 4) sel = sel % 8;
    case (sel)
      0: put(8'($urandom_range(8'h00, 8'h7F)));
      1: put(8'($urandom_range(8'hE0, 8'hFF)));
      2: begin
        n = $urandom_range(0, 2);
        put(n == 0 ? 8'hC0 : (n == 1 ? 8'hC2 : 8'hC3));
      end
      3: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
        put(8'hA0 | n[7:0]);
        put_rand(n);
      end
      4: begin
        n = $urandom_range(0, 5);
        put($urandom_range(0, 1) ? 8'hC4 : 8'hD9);
        put(n[7:0]);
        put_rand(n);
      end
      5: begin
        n = $urandom_range(0, 5);
        case ($urandom_range(0, 3))
          0: begin m = 8'hC5; nb = 2; end
          1: begin m = 8'hDA; nb = 2; end
          2: begin m = 8'hC6; nb = 4; end
          default: begin m = 8'hDB; nb = 4; end
        endcase
        put(m);
        put_be(n, nb);
        put_rand(n);
      end
      6: begin
        n = $urandom_range(0, 4);
        nb = $urandom_range(0, 2);
        put(nb == 0 ? 8'hC7 : (nb == 1 ? 8'hC8 : 8'hC9));
        put_be(n, nb == 0 ? 1 : (nb == 1 ? 2 : 4));
        put_rand(n + 1);
      end
      7: begin
        case ($urandom_range(0, 14))
          0: begin m = 8'hCC; n = 1; end
          1: begin m = 8'hD0; n = 1; end
          2: begin m = 8'hCD; n = 2; end
          3: begin m = 8'hD1; n = 2; end
          4: begin m = 8'hD4; n = 2; end
          5: begin m = 8'hD5; n = 3; end
          6: begin m = 8'hCA; n = 4; end
          7: begin m = 8'hCE; n = 4; end
          8: begin m = 8'hD2; n = 4; end
          9: begin m = 8'hD6; n = 5; end
          10: begin m = 8'hCB; n = 8; end
          11: begin m = 8'hCF; n = 8; end
          12: begin m = 8'hD3; n = 8; end
          13: begin m = 8'hD7; n = 9; end
          default: begin m = 8'hD8; n = 17; end
        endcase
        put(m);
        put_rand(n);
      end
      8: begin
        n = ($urandom_range(0, 15) == 0) ? 15 : $urandom_range(0, 4);
        put(8'h90 | n[7:0]);
        for (int i = 0; i < n; i++) gen_value(d + 1);
      end
      9: begin
        n = $urandom_range(0, 3);
        put(8'h80 | n[7:0]);
        for (int i = 0; i < 2 * n; i++) gen_value(d + 1);
      end
      default: begin
        n = $urandom_range(0, (cur_limit < 3) ? cur_limit : 3);
        case ($urandom_range(0, 3))
          0: begin m = 8'hDC; nb = 2; end
          1: begin m = 8'hDD; nb = 4; end
          2: begin m = 8'hDE; nb = 2; end
          default: begin m = 8'hDF; nb = 4; end
        endcase
        put(m);
        put_be(n, nb);
        if (m == 8'hDE || m == 8'hDF) n = 2 * n;
        for (int i = 0; i < n; i++) gen_value(d + 1);
      end
    endcase
  endtask

  task automatic mark_last();
    strm_q[strm_q.size() - 1][8] = 1'b1;
  endtask

  task automatic send_stream();
    logic [8:0] w;
    while (strm_q.size() > 0) begin
      w = strm_q.pop_front();
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      end
      burst_left--;
      in_valid <= 1'b1;
      in_byte <= w[7:0];
      in_last <= w[8];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_item_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = v;
  endtask

  // receiver: one long hold-off early, then random stall patterns
  initial begin
    int mode;
    int n;
    logic [7:0] pat;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (100) begin
      @(posedge clk);
      out_ready <= 1'b1;
    end
    for (int i = 0; i < 300; i++) begin
      @(posedge clk);
      out_ready <= 1'b0;
    end
    forever begin
      mode = $urandom_range(0, 2);
      n = $urandom_range(20, 80);
      pat = 8'($urandom_range(0, 255));
      for (int i = 0; i < n; i++) begin
        @(posedge clk);
        if (mode == 0) out_ready <= 1'b1;
        else if (mode == 1) out_ready <= ($urandom_range(0, 9) < 7);
        else out_ready <= pat[i % 8];
      end
    end
  end

  initial begin
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte <= '0;
    in_last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_item_limit <= '0;
    cur_limit = mvs_pkg::ITEM_LIMIT_RST;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scalar extremes, empty containers, long fixext, zero-length ext, 32-bit lengths
    put(8'h00); put(8'h7F); put(8'hE0); put(8'hFF);
    put(8'hC0); put(8'hC2); put(8'hC3); put(8'hA0);
    put(8'h80); put(8'h90);
    put(8'hD8); put_rand(17);
    put(8'hC9); put_be(0, 4); put_rand(1);
    put(8'hC6); put_be(1, 4); put_rand(1);
    put(8'hDD); put_be(0, 4);
    put(8'hDF); put_be(1, 4); put(8'h01); put(8'hC0);
    mark_last();
    // deepest legal nesting, closed by one scalar
    for (int i = 0; i < mvs_pkg::MAX_DEPTH_DEF; i++) put(8'h91);
    put(8'h05);
    mark_last();
    send_stream();

    for (int ph_i = 0; ph_i < 5; ph_i++) begin
      case (ph_i)
        0: write_limit(24'hFFFFFF);
        1: write_limit(24'd0);
        2: write_limit(24'($urandom_range(0, 24'hFFFFFF)));
        3: write_limit(mvs_pkg::ITEM_LIMIT_RST);
        default: write_limit(24'($urandom_range(1, 3)));
      endcase
      while (strm_q.size() < 50) begin
        gen_value(0);
        if ($urandom_range(0, 3) == 0) mark_last();
      end
      send_stream();
    end

    wait_drain();
    pick = $urandom_range(0, 3);
    case (pick)
      0: begin put(8'h92); put(8'h01); put(mvs_pkg::MARK_RESERVED); end
      1: begin put(8'hDD); put_be({8'd0, cur_limit} + 32'd1, 4); end
      2: begin
        for (int i = 0; i <= mvs_pkg::MAX_DEPTH_DEF; i++) put(8'h91);
        put(8'h00);
      end
      default: begin put(8'h92); put(8'h01); mark_last(); end
    endcase
    for (int i = 0; i < 6; i++) strm_q.insert(strm_q.size(), 9'($urandom_range(0, 511)));
    send_stream();

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
